/* rtl/core/rsdp_pkg.sv */
`timescale 1ns / 1ps

package rsdp_pkg;

    localparam int NUM_TRACKERS       = 4;
    localparam int MAX_STRUCT_LEN_DEF = 64;
    localparam int ADDR_W             = 21;

    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

    // Byte offsets inside the structure
    localparam int SIG_LEN     = 8;
    localparam int REV_OFS     = 15;
    localparam int V1_LAST     = 19;
    localparam int LEN_FIRST   = 20;
    localparam int LEN_LAST    = 23;
    localparam int MIN_V2_LEN  = 24;
    localparam int MIN_V2_REV  = 2;

    localparam logic [7:0] SIG_FIRST = 8'h52;

    // "RSD PTR "
    function automatic logic [7:0] sig_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = 8'h52;
            3'd1:    b = 8'h53;
            3'd2:    b = 8'h44;
            3'd3:    b = 8'h20;
            3'd4:    b = 8'h50;
            3'd5:    b = 8'h54;
            3'd6:    b = 8'h52;
            default: b = 8'h20;
        endcase
        return b;
    endfunction

    typedef struct packed {
        logic [7:0]        data;
        logic [ADDR_W-1:0] addr;
        logic              start_hit;
        logic              scan_end;
    } t_item;

endpackage

/* rtl/core/rsdp_front.sv */
`timescale 1ns / 1ps

module rsdp_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [7:0]           i_data_byte,
    input  logic [20:0]          i_byte_address,
    input  logic                 i_start_allowed,
    input  logic                 i_end_of_scan,
    output logic                 o_item_valid,
    input  logic                 i_item_pop,
    output rsdp_pkg::t_item      o_item
);
    import rsdp_pkg::*;

    t_item                 r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr;
    logic [FIFO_PTR_W-1:0] r_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_count;
    logic                  push;
    logic                  pop;
    t_item                 new_item;

    assign o_stall      = (r_count == FIFO_CNT_W'(FIFO_DEPTH));
    assign push         = i_valid && !o_stall;
    assign o_item_valid = (r_count != '0);
    assign pop          = i_item_pop && o_item_valid;
    assign o_item       = r_mem[r_rd_ptr];

    always_comb begin
        new_item.data      = i_data_byte;
        new_item.addr      = i_byte_address;
        new_item.start_hit = i_start_allowed && (i_data_byte == SIG_FIRST);
        new_item.scan_end  = i_end_of_scan;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= new_item;
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("queue count out of range");

    a_ptr_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr_ptr - r_rd_ptr) == r_count[FIFO_PTR_W-1:0])
        else $error("queue pointers disagree with count");

    a_push_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && pop |=> r_count == $past(r_count))
        else $error("simultaneous push and pop changed count");

endmodule

/* rtl/core/rsdp_back.sv */
`timescale 1ns / 1ps

module rsdp_back #(
    parameter int MAX_STRUCT_LEN = rsdp_pkg::MAX_STRUCT_LEN_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_item_valid,
    output logic                 o_item_pop,
    input  rsdp_pkg::t_item      i_item,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic                 o_found,
    output logic [20:0]          o_found_address,
    output logic [7:0]           o_found_revision,
    output logic                 o_last
);
    import rsdp_pkg::*;

    localparam int CW   = $clog2(MAX_STRUCT_LEN);
    localparam int LW   = $clog2(MAX_STRUCT_LEN + 1);
    localparam int CMPW = LW + 1;

    logic [NUM_TRACKERS-1:0] r_active;
    logic [ADDR_W-1:0]       r_start [NUM_TRACKERS];
    logic [CW-1:0]           r_cnt   [NUM_TRACKERS];
    logic [7:0]              r_sum   [NUM_TRACKERS];
    logic [7:0]              r_rev   [NUM_TRACKERS];
    logic [LW-1:0]           r_len   [NUM_TRACKERS];
    logic [NUM_TRACKERS-1:0] r_big;
    logic                    r_done;
    logic [ADDR_W-1:0]       r_best_addr;
    logic [7:0]              r_best_rev;

    logic                    r_out_valid;
    logic                    r_out_found;
    logic [ADDR_W-1:0]       r_out_addr;
    logic [7:0]              r_out_rev;

    logic [NUM_TRACKERS-1:0] n_active;
    logic [CW-1:0]           n_cnt   [NUM_TRACKERS];
    logic [7:0]              n_sum   [NUM_TRACKERS];
    logic [7:0]              n_rev   [NUM_TRACKERS];
    logic [LW-1:0]           n_len   [NUM_TRACKERS];
    logic [NUM_TRACKERS-1:0] n_big;
    logic [NUM_TRACKERS-1:0] rec;
    logic [NUM_TRACKERS-1:0] alloc_vec;
    logic                    n_done;
    logic [ADDR_W-1:0]       n_best_addr;
    logic [7:0]              n_best_rev;
    logic                    pop;

    assign pop        = i_item_valid && (!i_item.scan_end || !r_out_valid || !i_stall);
    assign o_item_pop = pop;

    // Per-tracker byte feed
    always_comb begin
        logic [CW-1:0] c;
        logic [31:0]   ext;
        logic          in_len;
        logic          fail;
        for (int t = 0; t < NUM_TRACKERS; t++) begin
            c        = r_cnt[t];
            in_len   = (c >= CW'(LEN_FIRST)) && (c <= CW'(LEN_LAST));
            ext      = 32'(i_item.data) << {c[1:0], 3'b000};
            n_sum[t] = r_sum[t] + i_item.data;
            n_rev[t] = (c == CW'(REV_OFS)) ? i_item.data : r_rev[t];
            n_len[t] = r_len[t] | (in_len ? ext[LW-1:0] : '0);
            n_big[t] = r_big[t] | (in_len && (|ext[31:LW]));
            n_cnt[t] = c + 1'b1;
            fail     = 1'b0;
            rec[t]   = 1'b0;
            if ((c < CW'(SIG_LEN)) && (i_item.data != sig_byte(c[2:0]))) begin
                fail = 1'b1;
            end else if ((c == CW'(V1_LAST)) && (n_sum[t] != 8'd0)) begin
                fail = 1'b1;
            end else if ((c == CW'(V1_LAST)) && (n_rev[t] < 8'(MIN_V2_REV))) begin
                rec[t] = 1'b1;
            end else if ((c == CW'(LEN_LAST)) && (n_big[t] || (n_len[t] < LW'(MIN_V2_LEN))
                         || (n_len[t] > LW'(MAX_STRUCT_LEN)))) begin
                fail = 1'b1;
            end else if ((c >= CW'(LEN_LAST))
                         && ((CMPW'(c) + 1'b1) == CMPW'(n_len[t]))) begin
                if (n_sum[t] == 8'd0) begin
                    rec[t] = 1'b1;
                end else begin
                    fail = 1'b1;
                end
            end
            rec[t]      = rec[t] && r_active[t];
            n_active[t] = r_active[t] && !fail && !rec[t];
        end
    end

    // Lowest address wins; ties keep the earlier record
    always_comb begin
        n_done      = r_done;
        n_best_addr = r_best_addr;
        n_best_rev  = r_best_rev;
        for (int t = 0; t < NUM_TRACKERS; t++) begin
            if (rec[t] && (!n_done || (r_start[t] < n_best_addr))) begin
                n_done      = 1'b1;
                n_best_addr = r_start[t];
                n_best_rev  = n_rev[t];
            end
        end
    end

    always_comb begin
        logic taken;
        taken     = 1'b0;
        alloc_vec = '0;
        for (int t = 0; t < NUM_TRACKERS; t++) begin
            if (i_item.start_hit && !taken && !n_active[t]) begin
                alloc_vec[t] = 1'b1;
                taken        = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= '0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (pop) begin
                if (i_item.scan_end) begin
                    r_active <= '0;
                    r_done   <= 1'b0;
                end else begin
                    r_active <= n_active | alloc_vec;
                    r_done   <= n_done;
                end
            end
            if (pop && i_item.scan_end) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_best_addr <= n_best_addr;
            r_best_rev  <= n_best_rev;
            for (int t = 0; t < NUM_TRACKERS; t++) begin
                if (alloc_vec[t]) begin
                    // first signature byte already matched
                    r_start[t] <= i_item.addr;
                    r_cnt[t]   <= CW'(1);
                    r_sum[t]   <= i_item.data;
                    r_rev[t]   <= 8'd0;
                    r_len[t]   <= '0;
                    r_big[t]   <= 1'b0;
                end else begin
                    r_cnt[t]   <= n_cnt[t];
                    r_sum[t]   <= n_sum[t];
                    r_rev[t]   <= n_rev[t];
                    r_len[t]   <= n_len[t];
                    r_big[t]   <= n_big[t];
                end
            end
            if (i_item.scan_end) begin
                r_out_found <= n_done;
                r_out_addr  <= n_done ? n_best_addr : '0;
                r_out_rev   <= n_done ? n_best_rev : 8'd0;
            end
        end
    end

    assign o_valid          = r_out_valid;
    assign o_found          = r_out_found;
    assign o_found_address  = r_out_addr;
    assign o_found_revision = r_out_rev;
    assign o_last           = 1'b1;

    a_scan_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop && i_item.scan_end |=> (r_active == '0) && !r_done)
        else $error("tracker state not cleared after scan end");

    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_found |-> (r_out_addr == '0) && (r_out_rev == 8'd0))
        else $error("not-found result carries nonzero fields");

    a_alloc_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_item_valid |-> $onehot0(alloc_vec) && ((alloc_vec & n_active) == '0))
        else $error("tracker allocation collides");

endmodule

/* rtl/core/acpi_root_pointer_scanner_core.sv */
`timescale 1ns / 1ps

// ACPI root pointer scanner.
// Input channel: one memory byte per word with its address, a start flag
// (host marks bytes where a candidate may begin) and an end-of-scan flag on
// the final byte. Accepted when i_valid is high and o_stall is low.
// Output channel: one word per scan (found, address, revision, last = 1),
// taken when o_valid is high and i_stall is low.
// Throughput: one byte per cycle; a four-entry queue separates the input
// classifier from the four candidate trackers, so o_stall rises only when
// that queue fills.
// The result word is registered: the final byte passes through the queue,
// and the result is set when the trackers take it from there. While a result
// waits under i_stall, bytes of the next scan keep flowing; only the next
// end-of-scan byte waits in the queue.
// Reset (synchronous, active low) empties the queue, frees all trackers and
// drops any pending result.
module acpi_root_pointer_scanner_core #(
    parameter int MAX_STRUCT_LEN = rsdp_pkg::MAX_STRUCT_LEN_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic [20:0] i_byte_address,
    input  logic        i_start_allowed,
    input  logic        i_end_of_scan,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_found,
    output logic [20:0] o_found_address,
    output logic [7:0]  o_found_revision,
    output logic        o_last
);
    import rsdp_pkg::*;

    t_item item;
    logic  item_valid;
    logic  item_pop;

    rsdp_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_data_byte     (i_data_byte),
        .i_byte_address  (i_byte_address),
        .i_start_allowed (i_start_allowed),
        .i_end_of_scan   (i_end_of_scan),
        .o_item_valid    (item_valid),
        .i_item_pop      (item_pop),
        .o_item          (item)
    );

    rsdp_back #(
        .MAX_STRUCT_LEN (MAX_STRUCT_LEN)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_item_valid     (item_valid),
        .o_item_pop       (item_pop),
        .i_item           (item),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_found          (o_found),
        .o_found_address  (o_found_address),
        .o_found_revision (o_found_revision),
        .o_last           (o_last)
    );

endmodule
